[rtl/sha256_pkg.sv]
// Shared types, constants and round functions of the SHA-256 hash engine.
package sha256_pkg;

  localparam int DIGEST_BYTES = 32;
  localparam int DIGEST_WORDS = DIGEST_BYTES / 4;
  localparam int BLOCK_BYTES  = 2 * DIGEST_BYTES;
  localparam int ROUNDS       = 64;

  typedef logic [31:0]       word_t;
  typedef logic [7:0][31:0]  hvec_t;    // element 0 is H0 / a

  // Control of the message schedule window.
  typedef struct packed {
    logic       load;     // shift one byte in at the low end
    logic [7:0] din;      // byte to shift in
    logic       step;     // roll the window by one word
    logic       expand;   // new word comes from the sigma expansion
  } sched_ctl_t;

  localparam hvec_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(input word_t v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t v);
    ssig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t ssig1(input word_t v);
    ssig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic word_t bsig0(input word_t v);
    bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t bsig1(input word_t v);
    bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

[rtl/sha256_sched.sv]
// Block buffer and rolling 16-word message schedule window.
module sha256_sched
  import sha256_pkg::*;
(
  input  logic       clk,
  input  sched_ctl_t ctl,
  output word_t      wt
);

  // Word j (0 = oldest) sits at bits [511-32j -: 32]; bytes enter at the bottom.
  logic [511:0] win_r;
  logic [511:0] win_nxt;
  word_t        w_exp;

  assign w_exp = ssig1(win_r[63:32]) + win_r[223:192] + ssig0(win_r[479:448])
               + win_r[511:480];
  assign wt    = ctl.expand ? w_exp : win_r[511:480];

  always_comb begin
    win_nxt = win_r;
    if (ctl.load) begin
      win_nxt = {win_r[503:0], ctl.din};
    end else if (ctl.step) begin
      win_nxt = {win_r[479:0], wt};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

[rtl/sha256_round.sv]
// One SHA-256 compression round on the working variables.
module sha256_round
  import sha256_pkg::*;
(
  input  hvec_t work,
  input  word_t kt,
  input  word_t wt,
  output hvec_t work_out
);

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  assign ch  = (work[4] & work[5]) | (~work[4] & work[6]);
  assign maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1  = work[7] + bsig1(work[4]) + ch + kt + wt;
  assign t2  = bsig0(work[0]) + maj;

  always_comb begin
    work_out[7] = work[6];
    work_out[6] = work[5];
    work_out[5] = work[4];
    work_out[4] = work[3] + t1;
    work_out[3] = work[2];
    work_out[2] = work[1];
    work_out[1] = work[0];
    work_out[0] = t1 + t2;
  end

endmodule

[rtl/sha256_hash_engine.sv]
// Top level of the SHA-256 hash engine: byte intake, padding, round sequencer, digest out.
//
//   channel | dir | tdata                | tuser             | tlast
//   --------+-----+----------------------+-------------------+--------------
//   in_     | in  | [7:0] data_byte      | [0] byte_present  | message_end
//   out_    | out | [31:0] digest_word   | [2:0] word_index  | last_word
//
// A byte beat is taken while the engine is idle; the beat that fills the 64-byte
// block starts 64 rounds on the shared round unit plus one chaining add, during
// which no further byte is taken.
// A message-end beat shifts in 9 to 72 pad bytes one per cycle, pausing once
// before the length field and while each block they complete is compressed;
// then eight digest beats are offered. in_tready is low from the end beat until
// the last one.
// Reset (rst_n low, synchronous) loads the initial hash and clears the count.
// A stalled out_tready holds the current digest beat.
module sha256_hash_engine
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic [0:0]  in_tuser,    // [0] byte_present
  input  logic        in_tlast,    // message_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] digest_word
  output logic [2:0]  out_tuser,   // [2:0] word_index
  output logic        out_tlast    // last_word
);

  localparam logic [5:0] LAST_POS  = 6'(BLOCK_BYTES - 1);
  localparam logic [5:0] LEN_POS   = 6'(BLOCK_BYTES - 8);
  localparam logic [5:0] LAST_RND  = 6'(ROUNDS - 1);
  localparam logic [2:0] LAST_WORD = 3'(DIGEST_WORDS - 1);
  localparam logic [2:0] LAST_LEN  = 3'd7;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ROUND, S_ADD, S_OUT
  } state_t;

  // Where the finishing sequence stands; PH_DATA means no message end pending.
  typedef enum logic [2:0] {
    PH_DATA, PH_MARK, PH_ZERO, PH_LEN, PH_DONE
  } phase_t;

  state_t      state_r,  state_nxt;
  phase_t      phase_r,  phase_nxt;
  hvec_t       chain_r,  chain_nxt;
  hvec_t       work_r,   work_nxt;
  logic [60:0] total_r,  total_nxt;
  logic [5:0]  pos_r,    pos_nxt;
  logic [5:0]  rnd_r,    rnd_nxt;
  logic [2:0]  lc_r,     lc_nxt;
  logic [2:0]  oidx_r,   oidx_nxt;

  sched_ctl_t  sctl;
  word_t       wt;
  hvec_t       work_rnd;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic        pad_shift;
  logic [7:0]  pad_byte;
  logic        in_acc;
  logic        out_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = chain_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == LAST_WORD);
  assign in_acc     = in_tvalid & in_tready;
  assign out_acc    = out_tvalid & out_tready;

  // Bit length goes out most significant byte first.
  assign len_bits = {total_r, 3'b000};
  assign len_byte = 8'(len_bits >> {~lc_r, 3'b000});

  sha256_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .wt  (wt)
  );

  sha256_round u_round (
    .work     (work_r),
    .kt       (round_k(rnd_r)),
    .wt       (wt),
    .work_out (work_rnd)
  );

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    chain_nxt = chain_r;
    work_nxt  = work_r;
    total_nxt = total_r;
    pos_nxt   = pos_r;
    rnd_nxt   = rnd_r;
    lc_nxt    = lc_r;
    oidx_nxt  = oidx_r;
    sctl      = '0;
    pad_shift = 1'b0;
    pad_byte  = 8'h00;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0]) begin
            sctl.load = 1'b1;
            sctl.din  = in_tdata;
            pos_nxt   = pos_r + 6'd1;
            total_nxt = total_r + 61'd1;
          end
          if (in_tlast) begin
            phase_nxt = PH_MARK;
          end
          // A full block compresses before any padding starts.
          if (in_tuser[0] && pos_r == LAST_POS) begin
            state_nxt = S_ROUND;
            work_nxt  = chain_r;
            rnd_nxt   = '0;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end

      S_PAD: begin
        case (phase_r)
          PH_MARK: begin
            pad_shift = 1'b1;
            pad_byte  = PAD_MARK;
            phase_nxt = PH_ZERO;
          end
          PH_ZERO: begin
            if (pos_r == LEN_POS) begin
              phase_nxt = PH_LEN;
              lc_nxt    = '0;
            end else begin
              pad_shift = 1'b1;
            end
          end
          PH_LEN: begin
            pad_shift = 1'b1;
            pad_byte  = len_byte;
            lc_nxt    = lc_r + 3'd1;
            if (lc_r == LAST_LEN) begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
        if (pad_shift) begin
          sctl.load = 1'b1;
          sctl.din  = pad_byte;
          pos_nxt   = pos_r + 6'd1;
          if (pos_r == LAST_POS) begin
            state_nxt = S_ROUND;
            work_nxt  = chain_r;
            rnd_nxt   = '0;
          end
        end
      end

      S_ROUND: begin
        sctl.step   = 1'b1;
        sctl.expand = |rnd_r[5:4];
        work_nxt    = work_rnd;
        rnd_nxt     = rnd_r + 6'd1;
        if (rnd_r == LAST_RND) begin
          state_nxt = S_ADD;
        end
      end

      S_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        if (phase_r == PH_DATA) begin
          state_nxt = S_IDLE;
        end else if (phase_r == PH_DONE) begin
          state_nxt = S_OUT;
          oidx_nxt  = '0;
        end else begin
          state_nxt = S_PAD;
        end
      end

      S_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 3'd1;
          // Restart from the initial hash once the last word is taken.
          if (oidx_r == LAST_WORD) begin
            chain_nxt = INIT_HASH;
            total_nxt = '0;
            phase_nxt = PH_DATA;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DATA;
      chain_r <= INIT_HASH;
      total_r <= '0;
      pos_r   <= '0;
      rnd_r   <= '0;
      lc_r    <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      chain_r <= chain_nxt;
      total_r <= total_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      lc_r    <= lc_nxt;
      oidx_r  <= oidx_nxt;
    end
    work_r <= work_nxt;
  end

`ifndef NO_ASSERTIONS
  // Intake and digest output never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest is offered");

  // After the 64th round comes the chaining add.
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == LAST_RND) |=> (state_r == S_ADD))
    else $error("round count did not end in chaining add");

  // A digest burst runs through all eight words.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("digest burst cut short");

  // After the last word the engine is back at the initial hash and ready.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=>
      (in_tready && total_r == '0 && chain_r == INIT_HASH))
    else $error("engine did not restart after digest");
`endif

endmodule
